### design/principal_axis_vector_rotator_unit_assert.svh
// Assertion macros for the principal axis rotator checker.
`ifndef PRINCIPAL_AXIS_VECTOR_ROTATOR_UNIT_ASSERT_SVH
`define PRINCIPAL_AXIS_VECTOR_ROTATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define PAVR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("principal axis rotator: check failed");

// next-cycle implication
`define PAVR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("principal axis rotator: check failed");

`endif

### design/pavr_pkg.sv
package pavr_pkg;

	localparam int GUARD_BITS = 12;

	localparam logic [1:0] AXIS_X   = 2'd0;
	localparam logic [1:0] AXIS_Y   = 2'd1;
	localparam logic [1:0] AXIS_Z   = 2'd2;
	localparam logic [1:0] AXIS_BAD = 2'd3;

	// atan(2^-i) in 2^-32 turn units
	localparam logic [31:0] ATAN_TURNS [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	// CORDIC gain compensation, unsigned Q1.31; elaboration only
	function automatic logic [31:0] gain_k(input int steps);
		logic [63:0] p;
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] bit_v;
		logic [63:0] s;
		logic [63:0] rem;
		logic [63:0] q;
		int i;
		p = 64'd1 << 60;
		for (i = 0; i < 32; i++) begin
			if (i < steps) begin
				p = p + (p >> (2 * i));
			end
		end
		n = p;
		res = '0;
		bit_v = 64'd1 << 62;
		for (i = 0; i < 32; i++) begin
			if (n >= res + bit_v) begin
				n = n - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		s = (res == '0) ? 64'd1 : res;
		rem = '0;
		q = '0;
		for (i = 61; i >= 0; i--) begin
			rem = {rem[62:0], (i == 61) ? 1'b1 : 1'b0};
			if (rem >= s) begin
				rem = rem - s;
				q[i] = 1'b1;
			end
		end
		return q[31:0];
	endfunction

endpackage

### design/principal_axis_vector_rotator_unit.sv
// Principal axis vector rotator.
// Rotates a signed Q16.16 3-vector about the x, y or z axis by a binary angle
// (2^ANGLE_BITS units per turn, right-handed). Component along the axis passes
// unchanged; rotated components are rounded and saturated. Axis code 3 passes
// the vector unchanged and flags bad_axis.
// Input: a transfer happens on a rising edge with start high and busy low.
// busy is high during reset and until the first rising edge after it, then stays low:
// one vector per clock, back to back.
// Output: done is high for one cycle with x_out, y_out, z_out and bad_axis.
// done and the results pass through the input stage, the CORDIC chain (one
// register stage per iteration) and four stages for magnitude and sign, gain
// multiply, rounding and saturation.
// Receiver cannot stall; results are presented once and never held.
// Reset clears all valid bits; items in flight are dropped.
module principal_axis_vector_rotator_unit #(
	parameter int COMPONENT_BITS = 32,
	parameter int ANGLE_BITS     = 16,
	parameter int CORDIC_STEPS   = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [COMPONENT_BITS-1:0] x_in,
	input  logic signed [COMPONENT_BITS-1:0] y_in,
	input  logic signed [COMPONENT_BITS-1:0] z_in,
	input  logic        [1:0]                axis,
	input  logic        [ANGLE_BITS-1:0]     turn_angle,
	output logic                             done,
	output logic signed [COMPONENT_BITS-1:0] x_out,
	output logic signed [COMPONENT_BITS-1:0] y_out,
	output logic signed [COMPONENT_BITS-1:0] z_out,
	output logic                             bad_axis
);

	localparam int CB = COMPONENT_BITS;
	localparam int GB = pavr_pkg::GUARD_BITS;
	localparam int W  = CB + GB + 3;
	localparam int MW = W - 1;
	localparam int ML = (MW + 1) / 2;
	localparam int MH = MW - ML;
	localparam int KW = 32;
	localparam int PW = MW + KW + 1;
	localparam int RS = 31 + GB;
	localparam int RW = PW - RS;
	localparam int ZW = 34;
	localparam logic [KW-1:0] GAIN = pavr_pkg::gain_k(CORDIC_STEPS);
	localparam logic [PW-1:0] ONE_P = {{(PW-1){1'b0}}, 1'b1};
	localparam logic [PW-1:0] RND = (ONE_P << 30) | (ONE_P << (RS - 1));
	localparam logic signed [CB-1:0] MAXV = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] MINV = {1'b1, {(CB-1){1'b0}}};

	typedef struct packed {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic signed [CB-1:0] z;
		logic [1:0]           axis;
	} pass_t;

	typedef struct packed {
		logic signed [W-1:0]  a;
		logic signed [W-1:0]  b;
		logic signed [ZW-1:0] ang;
		pass_t                ps;
	} cor_t;

	function automatic logic signed [CB-1:0] sat_val(input logic [RW-1:0] r, input logic neg);
		logic                 ov;
		logic signed [CB-1:0] lo;
		ov = |r[RW-1:CB-1];
		lo = r[CB-1:0];
		if (neg) begin
			sat_val = ov ? MINV : -lo;
		end else begin
			sat_val = ov ? MAXV : lo;
		end
	endfunction

	logic busy_q;
	logic acc;

	assign busy = busy_q;
	assign acc  = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	// stage 1: pair select, half-turn fold, guard shift
	logic signed [CB-1:0] ra;
	logic signed [CB-1:0] rb;
	logic [31:0]          t_full;
	logic                 flip;
	logic [31:0]          t_res;
	logic signed [W-1:0]  wa;
	logic signed [W-1:0]  wb;
	cor_t                 pre_nxt;
	cor_t                 pre_s1;
	logic                 pre_v_s1;

	always_comb begin
		unique case (axis)
			pavr_pkg::AXIS_X: begin
				ra = y_in;
				rb = z_in;
			end
			pavr_pkg::AXIS_Y: begin
				ra = z_in;
				rb = x_in;
			end
			pavr_pkg::AXIS_Z: begin
				ra = x_in;
				rb = y_in;
			end
			default: begin
				ra = x_in;
				rb = y_in;
			end
		endcase
		t_full = {turn_angle, {(32-ANGLE_BITS){1'b0}}};
		flip   = t_full[31] ^ t_full[30];
		t_res  = {t_full[31] ^ flip, t_full[30:0]};
		wa = W'(ra);
		wb = W'(rb);
		if (flip) begin
			wa = -wa;
			wb = -wb;
		end
		pre_nxt.a       = wa <<< GB;
		pre_nxt.b       = wb <<< GB;
		pre_nxt.ang     = {{(ZW-32){t_res[31]}}, t_res};
		pre_nxt.ps.x    = x_in;
		pre_nxt.ps.y    = y_in;
		pre_nxt.ps.z    = z_in;
		pre_nxt.ps.axis = axis;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_v_s1 <= 1'b0;
		end else begin
			pre_v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pre_s1 <= pre_nxt;
		end
	end

	// CORDIC chain, one iteration per stage
	cor_t step_in  [CORDIC_STEPS];
	logic step_v   [CORDIC_STEPS];
	cor_t cor_s2   [CORDIC_STEPS];
	logic cor_v_s2 [CORDIC_STEPS];

	for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_step
		logic signed [W-1:0]  sa;
		logic signed [W-1:0]  sb;
		logic signed [W-1:0]  da;
		logic signed [W-1:0]  db;
		logic signed [ZW-1:0] za;
		logic signed [ZW-1:0] zt;
		cor_t                 nxt;

		if (gi == 0) begin : g_first
			assign step_in[gi] = pre_s1;
			assign step_v[gi]  = pre_v_s1;
		end else begin : g_next
			assign step_in[gi] = cor_s2[gi-1];
			assign step_v[gi]  = cor_v_s2[gi-1];
		end

		assign sa = step_in[gi].a;
		assign sb = step_in[gi].b;
		assign za = step_in[gi].ang;
		assign da = sb >>> gi;
		assign db = sa >>> gi;
		assign zt = {{(ZW-32){1'b0}}, pavr_pkg::ATAN_TURNS[gi]};

		always_comb begin
			nxt = step_in[gi];
			if (!za[ZW-1]) begin
				nxt.a   = sa - da;
				nxt.b   = sb + db;
				nxt.ang = za - zt;
			end else begin
				nxt.a   = sa + da;
				nxt.b   = sb - db;
				nxt.ang = za + zt;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cor_v_s2[gi] <= 1'b0;
			end else begin
				cor_v_s2[gi] <= step_v[gi];
			end
		end

		always_ff @(posedge clk) begin
			if (step_v[gi]) begin
				cor_s2[gi] <= nxt;
			end
		end
	end

	// stage 3: magnitude and sign
	cor_t                last;
	logic                last_v;
	logic signed [W-1:0] la;
	logic signed [W-1:0] lb;
	logic signed [W-1:0] abs_a;
	logic signed [W-1:0] abs_b;
	logic [MW-1:0]       mag_a_s3;
	logic [MW-1:0]       mag_b_s3;
	logic                neg_a_s3;
	logic                neg_b_s3;
	pass_t               ps_s3;
	logic                v_s3;

	assign last   = cor_s2[CORDIC_STEPS-1];
	assign last_v = cor_v_s2[CORDIC_STEPS-1];
	assign la     = last.a;
	assign lb     = last.b;
	assign abs_a  = la[W-1] ? -la : la;
	assign abs_b  = lb[W-1] ? -lb : lb;

	// stage 4: gain multiply, split into two partial products per component
	logic [ML+KW-1:0] pl_a_s4;
	logic [MH+KW-1:0] ph_a_s4;
	logic [ML+KW-1:0] pl_b_s4;
	logic [MH+KW-1:0] ph_b_s4;
	logic             neg_a_s4;
	logic             neg_b_s4;
	pass_t            ps_s4;
	logic             v_s4;

	// stage 5: both roundings folded into one add
	logic [PW-1:0] sum_a;
	logic [PW-1:0] sum_b;
	logic [RW-1:0] r_a_s5;
	logic [RW-1:0] r_b_s5;
	logic          neg_a_s5;
	logic          neg_b_s5;
	pass_t         ps_s5;
	logic          v_s5;

	assign sum_a = PW'({ph_a_s4, {ML{1'b0}}}) + PW'(pl_a_s4) + RND;
	assign sum_b = PW'({ph_b_s4, {ML{1'b0}}}) + PW'(pl_b_s4) + RND;

	// stage 6: saturate and place components
	logic signed [CB-1:0] fa;
	logic signed [CB-1:0] fb;
	logic signed [CB-1:0] ox;
	logic signed [CB-1:0] oy;
	logic signed [CB-1:0] oz;
	logic                 obad;
	logic signed [CB-1:0] x_s6;
	logic signed [CB-1:0] y_s6;
	logic signed [CB-1:0] z_s6;
	logic                 bad_s6;
	logic                 v_s6;

	always_comb begin
		fa   = sat_val(r_a_s5, neg_a_s5);
		fb   = sat_val(r_b_s5, neg_b_s5);
		ox   = ps_s5.x;
		oy   = ps_s5.y;
		oz   = ps_s5.z;
		obad = 1'b0;
		unique case (ps_s5.axis)
			pavr_pkg::AXIS_X: begin
				oy = fa;
				oz = fb;
			end
			pavr_pkg::AXIS_Y: begin
				oz = fa;
				ox = fb;
			end
			pavr_pkg::AXIS_Z: begin
				ox = fa;
				oy = fb;
			end
			default: begin
				obad = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s3 <= last_v;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (last_v) begin
			mag_a_s3 <= abs_a[MW-1:0];
			mag_b_s3 <= abs_b[MW-1:0];
			neg_a_s3 <= la[W-1];
			neg_b_s3 <= lb[W-1];
			ps_s3    <= last.ps;
		end
		if (v_s3) begin
			pl_a_s4  <= mag_a_s3[ML-1:0] * GAIN;
			ph_a_s4  <= mag_a_s3[MW-1:ML] * GAIN;
			pl_b_s4  <= mag_b_s3[ML-1:0] * GAIN;
			ph_b_s4  <= mag_b_s3[MW-1:ML] * GAIN;
			neg_a_s4 <= neg_a_s3;
			neg_b_s4 <= neg_b_s3;
			ps_s4    <= ps_s3;
		end
		if (v_s4) begin
			r_a_s5   <= sum_a[PW-1:RS];
			r_b_s5   <= sum_b[PW-1:RS];
			neg_a_s5 <= neg_a_s4;
			neg_b_s5 <= neg_b_s4;
			ps_s5    <= ps_s4;
		end
		if (v_s5) begin
			x_s6   <= ox;
			y_s6   <= oy;
			z_s6   <= oz;
			bad_s6 <= obad;
		end
	end

	assign done     = v_s6;
	assign x_out    = x_s6;
	assign y_out    = y_s6;
	assign z_out    = z_s6;
	assign bad_axis = bad_s6;

endmodule

### design/pavr_chk.sv
`include "principal_axis_vector_rotator_unit_assert.svh"

module pavr_chk #(
	parameter int COMPONENT_BITS = 32,
	parameter int CORDIC_STEPS   = 16
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic signed [COMPONENT_BITS-1:0] x_in,
	input logic signed [COMPONENT_BITS-1:0] y_in,
	input logic signed [COMPONENT_BITS-1:0] z_in,
	input logic        [1:0]                axis,
	input logic                             done,
	input logic signed [COMPONENT_BITS-1:0] x_out,
	input logic signed [COMPONENT_BITS-1:0] y_out,
	input logic signed [COMPONENT_BITS-1:0] z_out,
	input logic                             bad_axis
);

	localparam int LAT = CORDIC_STEPS + 5;
	localparam int CW  = $clog2(LAT + 1);
	localparam logic [CW-1:0] LAT_C = CW'(LAT);

	// cycles since reset release, saturating; items from before reset are gone
	logic [CW-1:0] since_rst_q;
	logic [3*COMPONENT_BITS-1:0] vec_in;
	logic [3*COMPONENT_BITS-1:0] vec_out;

	assign vec_in  = {x_in, y_in, z_in};
	assign vec_out = {x_out, y_out, z_out};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_rst_q <= '0;
		end else if (since_rst_q != LAT_C) begin
			since_rst_q <= since_rst_q + 1'b1;
		end
	end

	`PAVR_ASSERT_IMP(a_lat, clk, arst_n, since_rst_q == LAT_C && $past(start && !busy, LAT), done)
	`PAVR_ASSERT_IMP(a_no_spur, clk, arst_n, done, $past(start && !busy, LAT))
	`PAVR_ASSERT_IMP(a_bad, clk, arst_n, done, bad_axis == ($past(axis, LAT) == pavr_pkg::AXIS_BAD))
	`PAVR_ASSERT_IMP(a_pass, clk, arst_n, done && bad_axis, vec_out == $past(vec_in, LAT))
	`PAVR_ASSERT_NXT(a_busy, clk, arst_n, !busy, !busy)

endmodule

bind principal_axis_vector_rotator_unit pavr_chk #(
	.COMPONENT_BITS(COMPONENT_BITS),
	.CORDIC_STEPS  (CORDIC_STEPS)
) u_pavr_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.x_in    (x_in),
	.y_in    (y_in),
	.z_in    (z_in),
	.axis    (axis),
	.done    (done),
	.x_out   (x_out),
	.y_out   (y_out),
	.z_out   (z_out),
	.bad_axis(bad_axis)
);
